// File: sv/b64e_pkg.sv
// ----------------------------------------------------------------------------
// b64e_pkg
// shared types, the pad constant and the alphabet lookup for the base64 encoder
// ----------------------------------------------------------------------------
package b64e_pkg;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // one output character with its end-of-message flag
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_sym;

    // characters produced by one input byte, count minus one
    typedef struct packed {
        t_sym [3:0] syms;
        logic [1:0] cnt_m1;
    } t_work;

    // six-bit code to standard alphabet character
    function automatic logic [7:0] enc_char(input logic [5:0] six);
        logic [7:0] v;
        v = {2'b00, six};
        priority if (six < 6'd26) begin
            return 8'h41 + v;
        end else if (six < 6'd52) begin
            return 8'h61 + v - 8'd26;
        end else if (six < 6'd62) begin
            return 8'h30 + v - 8'd52;
        end else if (six == 6'd62) begin
            return 8'h2B;
        end else begin
            return 8'h2F;
        end
    endfunction

endpackage

// File: sv/b64e_if.sv
// ----------------------------------------------------------------------------
// b64e_if
// valid/ready channels for raw bytes in and encoded characters out
// ----------------------------------------------------------------------------
interface b64e_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface b64e_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_char;

    modport source (output valid, output out_char, output last_char, input ready);
    modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

// File: sv/b64e_front.sv
// ----------------------------------------------------------------------------
// b64e_front
// takes bytes, tracks group phase and carry, builds the characters per byte
// ----------------------------------------------------------------------------
module b64e_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    b64e_byte_if.sink            i_in,
    input  logic                 i_full,
    output logic                 o_push,
    output b64e_pkg::t_work      o_work
);

    typedef enum logic [1:0] {
        PH0,
        PH1,
        PH2
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [3:0] r_carry, n_carry;
    logic [7:0] b;
    logic       lst;

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;
    assign b          = i_in.data_byte;
    assign lst        = i_in.last_byte;

    always_comb begin
        o_work  = '0;
        n_phase = r_phase;
        n_carry = r_carry;
        unique case (r_phase)
            PH1: begin
                o_work.syms[0].ch = b64e_pkg::enc_char({r_carry[1:0], b[7:4]});
                o_work.syms[1].ch = b64e_pkg::enc_char({b[3:0], 2'b00});
                o_work.syms[2]    = '{ch: b64e_pkg::PAD_CHAR, last: 1'b1};
                o_work.cnt_m1     = lst ? 2'd2 : 2'd0;
                n_phase           = lst ? PH0 : PH2;
                n_carry           = lst ? 4'd0 : b[3:0];
            end
            PH2: begin
                o_work.syms[0].ch   = b64e_pkg::enc_char({r_carry, b[7:6]});
                o_work.syms[1].ch   = b64e_pkg::enc_char(b[5:0]);
                o_work.syms[1].last = lst;
                o_work.cnt_m1       = 2'd1;
                n_phase             = PH0;
                n_carry             = 4'd0;
            end
            default: begin
                // phase 0, carry ignored
                o_work.syms[0].ch = b64e_pkg::enc_char(b[7:2]);
                o_work.syms[1].ch = b64e_pkg::enc_char({b[1:0], 4'b0000});
                o_work.syms[2].ch = b64e_pkg::PAD_CHAR;
                o_work.syms[3]    = '{ch: b64e_pkg::PAD_CHAR, last: 1'b1};
                o_work.cnt_m1     = lst ? 2'd3 : 2'd0;
                n_phase           = lst ? PH0 : PH1;
                n_carry           = lst ? 4'd0 : {2'b00, b[1:0]};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH0;
            r_carry <= '0;
        end else if (o_push) begin
            r_phase <= n_phase;
            r_carry <= n_carry;
        end
    end

endmodule

// File: sv/b64e_queue.sv
// ----------------------------------------------------------------------------
// b64e_queue
// two-entry queue of per-byte character groups between front and back
// ----------------------------------------------------------------------------
module b64e_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  b64e_pkg::t_work      i_work,
    input  logic                 i_pop,
    output logic                 o_full,
    output logic                 o_valid,
    output b64e_pkg::t_work      o_work
);

    b64e_pkg::t_work r_mem [2];
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_work  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_work;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

// File: sv/b64e_back.sv
// ----------------------------------------------------------------------------
// b64e_back
// walks the queued groups and sends one character per beat
// ----------------------------------------------------------------------------
module b64e_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  b64e_pkg::t_work      i_work,
    output logic                 o_pop,
    b64e_char_if.source          o_out
);

    logic [1:0] r_idx;
    logic       r_valid;
    logic [7:0] r_char;
    logic       r_last;
    logic       load;

    assign load          = i_valid && (!r_valid || o_out.ready);
    assign o_pop         = load && (r_idx == i_work.cnt_m1);
    assign o_out.valid     = r_valid;
    assign o_out.out_char  = r_char;
    assign o_out.last_char = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx <= o_pop ? 2'd0 : r_idx + 2'd1;
            end
            if (load) begin
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_char <= i_work.syms[r_idx].ch;
            r_last <= i_work.syms[r_idx].last;
        end
    end

endmodule

// File: sv/base64_stream_encoder.sv
// ----------------------------------------------------------------------------
// base64_stream_encoder
// streaming standard base64 encoder, bytes in, ascii characters out
// ----------------------------------------------------------------------------
// usage
//   i_byte carries one raw byte per beat with a flag on the final byte of a
//   message; o_char carries one alphabet character or '=' per beat, flagged
//   on the final character of the message
//   each byte yields one character (first and second byte of a group) or two
//   (third byte); a flagged byte flushes the partial group with zero fill
//   and one or two '=' pads, up to four characters in all
//   the first character of a byte passes through the group queue and then
//   the output register, and the further characters of the group follow it
//   throughput: one character per cycle while the receiver is ready, set by
//   the single output register
//   the two-entry group queue and the output register let bytes keep
//   coming while a character waits on the receiver; when the queue fills,
//   i_byte.ready drops until the receiver takes characters again
//   reset clears group phase, carry, queue and output valid; a message that
//   follows a flagged byte starts a fresh group
// ----------------------------------------------------------------------------
module base64_stream_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    b64e_byte_if.sink   i_byte,
    b64e_char_if.source o_char
);

    // front to queue
    logic              push;
    logic              full;
    b64e_pkg::t_work   push_work;

    // queue to back
    logic              q_valid;
    logic              pop;
    b64e_pkg::t_work   head_work;

    // classify each byte by group phase and form its characters
    b64e_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_byte),
        .i_full  (full),
        .o_push  (push),
        .o_work  (push_work)
    );

    // decouples byte acceptance from character output
    b64e_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_work  (push_work),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_work  (head_work)
    );

    // serialize the group, one character per beat
    b64e_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_work  (head_work),
        .o_pop   (pop),
        .o_out   (o_char)
    );

endmodule

// File: sv/b64e_checker.sv
// ----------------------------------------------------------------------------
// b64e_checker
// port-level checks on the base64 encoder, bound to the top level
// ----------------------------------------------------------------------------
module b64e_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_char,
    input logic       i_out_last
);

    // stalled character stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_char)
            && $stable(i_out_last))
        else $error("output beat dropped under stall");

    // nothing offered right after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // only alphabet characters or pad
    a_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_char >= 8'h41 && i_out_char <= 8'h5A)
            || (i_out_char >= 8'h61 && i_out_char <= 8'h7A)
            || (i_out_char >= 8'h30 && i_out_char <= 8'h39)
            || i_out_char == 8'h2B || i_out_char == 8'h2F
            || i_out_char == b64e_pkg::PAD_CHAR)
        else $error("illegal output character");

    // an unflagged pad is followed at once by the flagged final pad
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_out_char == b64e_pkg::PAD_CHAR && !i_out_last
            |=> i_out_valid && i_out_char == b64e_pkg::PAD_CHAR && i_out_last)
        else $error("double pad sequence broken");

endmodule

bind base64_stream_encoder b64e_checker u_b64e_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_char.valid),
    .i_out_ready (o_char.ready),
    .i_out_char  (o_char.out_char),
    .i_out_last  (o_char.last_char)
);

// File: test/base64_stream_encoder_test.sv
// ----------------------------------------------------------------------------
// base64_stream_encoder_test
// drives byte messages through the base64 encoder and checks every character
// against an in-bench encoder, with random bursts, stalls and a long hold-off
// ----------------------------------------------------------------------------
module base64_stream_encoder_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CLK_HALF       = 5;
    localparam int  RESET_CYCLES   = 5;
    localparam int  WATCHDOG_LIMIT = 3000;
    localparam int  HOLD_CYCLES    = 300;
    localparam int  DRAIN_CYCLES   = 8;
    localparam int  RANDOM_BYTES   = 380;
    localparam int  MAX_PRINTED    = 40;

    // standard alphabet, index 0 in the top byte
    localparam logic [511:0] B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    // position of the next byte inside a three-byte group
    typedef enum logic [1:0] {
        GRP_FIRST,
        GRP_SECOND,
        GRP_THIRD
    } t_group_pos;

    // receiver stall patterns
    typedef enum logic [1:0] {
        RX_FULL,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } t_rx_mode;

    logic i_clk;
    logic i_rst_n;

    b64e_byte_if byte_bus ();
    b64e_char_if char_bus ();

    base64_stream_encoder u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_bus),
        .o_char  (char_bus)
    );

    // encoder state mirrored by the bench
    t_group_pos enc_phase = GRP_FIRST;
    logic [3:0] enc_carry = 4'h0;

    // characters still owed by the block, oldest first
    b64e_pkg::t_sym expected_chars[$];

    int         mismatches    = 0;
    int         burst_left    = 0;
    bit         steady_feed   = 1'b0;
    t_rx_mode   rx_mode       = RX_FULL;
    int         hold_requests = 0;

    wire bytes_moving = byte_bus.valid && byte_bus.ready;
    wire chars_moving = char_bus.valid && char_bus.ready;

    // ------------------------------------------------------------------------
    // clock and reset
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // in-bench encoder
    // ------------------------------------------------------------------------
    function automatic logic [7:0] alphabet_char(input logic [5:0] six);
        return B64_ALPHABET[8 * (63 - int'(six)) +: 8];
    endfunction

    function automatic void queue_char(input logic [7:0] ch, input logic fin);
        b64e_pkg::t_sym s;
        s.ch   = ch;
        s.last = fin;
        expected_chars.push_back(s);
    endfunction

    // characters caused by one accepted byte, and the group state after it
    function automatic void encode_byte(input logic [7:0] b, input logic fin);
        case (enc_phase)
            GRP_SECOND: begin
                // two carried bits on top of the high nibble
                queue_char(alphabet_char({enc_carry[1:0], b[7:4]}), 1'b0);
                if (fin) begin
                    queue_char(alphabet_char({b[3:0], 2'b00}), 1'b0);
                    queue_char(b64e_pkg::PAD_CHAR, 1'b1);
                    enc_phase = GRP_FIRST;
                    enc_carry = 4'h0;
                end else begin
                    enc_carry = b[3:0];
                    enc_phase = GRP_THIRD;
                end
            end
            GRP_THIRD: begin
                // group complete, both characters always come out
                queue_char(alphabet_char({enc_carry, b[7:6]}), 1'b0);
                queue_char(alphabet_char(b[5:0]), fin);
                enc_phase = GRP_FIRST;
                enc_carry = 4'h0;
            end
            default: begin
                // start of group, any old carry is ignored
                queue_char(alphabet_char(b[7:2]), 1'b0);
                if (fin) begin
                    queue_char(alphabet_char({b[1:0], 4'h0}), 1'b0);
                    queue_char(b64e_pkg::PAD_CHAR, 1'b0);
                    queue_char(b64e_pkg::PAD_CHAR, 1'b1);
                    enc_carry = 4'h0;
                    enc_phase = GRP_FIRST;
                end else begin
                    enc_carry = {2'b00, b[1:0]};
                    enc_phase = GRP_SECOND;
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // byte sender
    // ------------------------------------------------------------------------
    // one beat on the byte channel; valid stays high across back-to-back
    // beats and only drops when a burst runs out and a gap is taken
    task automatic send_byte(input logic [7:0] data, input logic fin);
        int gap;
        if (!steady_feed && burst_left == 0) begin
            byte_bus.valid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(1, 16);
        end
        byte_bus.valid     <= 1'b1;
        byte_bus.data_byte <= data;
        byte_bus.last_byte <= fin;
        do @(posedge i_clk); while (!byte_bus.ready);
        encode_byte(data, fin);
        if (burst_left > 0) burst_left--;
    endtask

    // whole message, the final byte flagged
    task automatic send_message(input logic [7:0] msg[$]);
        foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1);
    endtask

    task automatic send_random_message(input int len);
        logic [7:0] msg[$];
        repeat (len) msg.push_back(8'($urandom_range(0, 255)));
        send_message(msg);
    endtask

    // ------------------------------------------------------------------------
    // character receiver
    // ------------------------------------------------------------------------
    // ready follows the current stall pattern; a hold request overrides it
    // with a long stretch of ready low, counted here
    initial begin
        int hold_served;
        int hold_count;
        int cyc;
        hold_served = 0;
        hold_count  = 0;
        cyc         = 0;
        char_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (hold_served != hold_requests) begin
                char_bus.ready <= 1'b0;
                hold_count++;
                if (hold_count >= HOLD_CYCLES) begin
                    hold_count = 0;
                    hold_served++;
                end
            end else begin
                case (rx_mode)
                    RX_COIN:     char_bus.ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE:   char_bus.ready <= ($urandom_range(0, 3) == 0);
                    RX_PERIODIC: char_bus.ready <= ((cyc % 7) < 4);
                    default:     char_bus.ready <= 1'b1;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        if (mismatches < MAX_PRINTED)
            $display("%0t: mismatch, %s: got %h expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        b64e_pkg::t_sym want;
        if (i_rst_n && chars_moving) begin
            if (expected_chars.size() == 0) begin
                report_mismatch("character with none owed", char_bus.out_char, 8'h00);
            end else begin
                want = expected_chars.pop_front();
                if (char_bus.out_char !== want.ch)
                    report_mismatch("out_char", char_bus.out_char, want.ch);
                if (char_bus.last_char !== want.last)
                    report_mismatch("last_char", {7'd0, char_bus.last_char},
                                    {7'd0, want.last});
            end
        end
    end

    // ends the run when neither channel moves for too long
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || bytes_moving || chars_moving) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("base64_stream_encoder_test failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    // short messages ending in each group position, field extremes,
    // the two top alphabet codes and a stale carry before a one-byte message
    task automatic test_directed();
        rx_mode = RX_COIN;
        send_message('{8'h00});                 // last byte first in group
        send_message('{8'hFF});
        send_message('{8'h00, 8'hFF});          // last byte second in group
        send_message('{8'hFF, 8'hFF});          // leaves carry set, then cleared
        send_message('{8'h00});                 // must not see the old carry
        send_message('{8'hFB, 8'hEF, 8'hBE});   // all '+'
        send_message('{8'hFF, 8'hFF, 8'hFF});   // all '/'
        send_message('{8'h4D, 8'h61, 8'h6E});
        send_message('{8'h00, 8'h00, 8'h00, 8'h80});
        send_message('{8'h01, 8'h02, 8'h03, 8'h04, 8'h05});
    endtask

    // random messages, mostly short, some long, stall pattern per message
    task automatic test_random_messages();
        int sent;
        int len;
        sent = 0;
        while (sent < RANDOM_BYTES) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            if ($urandom_range(0, 7) == 0) len = $urandom_range(16, 40);
            else len = $urandom_range(1, 9);
            send_random_message(len);
            sent += len;
        end
    endtask

    // no idling on either side
    task automatic test_full_rate();
        rx_mode     = RX_FULL;
        steady_feed = 1'b1;
        send_random_message(14);
        send_random_message(16);
        steady_feed = 1'b0;
    endtask

    // receiver holds off while bytes keep coming, so the input must stall
    task automatic test_backpressure();
        rx_mode     = RX_FULL;
        steady_feed = 1'b1;
        hold_requests++;
        send_random_message(24);
        steady_feed = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n            <= 1'b0;
        byte_bus.valid     <= 1'b0;
        byte_bus.data_byte <= 8'h00;
        byte_bus.last_byte <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_full_rate();
        test_backpressure();
        test_random_messages();

        byte_bus.valid <= 1'b0;
        rx_mode = RX_COIN;
        while (expected_chars.size() != 0) @(posedge i_clk);
        // anything extra the block still puts out shows up here
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && expected_chars.size() == 0) begin
            $display("base64_stream_encoder_test passed");
        end else begin
            $display("base64_stream_encoder_test failed");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/b64e_pkg.sv
sv/b64e_if.sv
sv/b64e_front.sv
sv/b64e_queue.sv
sv/b64e_back.sv
sv/base64_stream_encoder.sv
sv/b64e_checker.sv
test/base64_stream_encoder_test.sv
